@@ hw/rtl/articulation_point_finder_top_defines.svh @@
// Assertion macros used by the checker file apf_checker.sv.
`ifndef ARTICULATION_POINT_FINDER_TOP_DEFINES_SVH
`define ARTICULATION_POINT_FINDER_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define APF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define APF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/apf_pkg.sv @@
// Package with the types and constants of the articulation point finder.
package apf_pkg;
   localparam int MaxVerticesDefault = 64;
   localparam int VertexCountReset   = 64;
   localparam int VidWidth           = 6;
   localparam int CountWidth         = 7;
   localparam int TimeWidth          = 7;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ROOT,
      ST_TOP_RD,
      ST_SCAN,
      ST_VISIT_RD,
      ST_DESCEND,
      ST_BACK_RD,
      ST_POP,
      ST_POP_WR,
      ST_EMIT,
      ST_CLEAR
   } apf_state_type;
endpackage

@@ hw/rtl/apf_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
interface apf_req_if import apf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VidWidth-1:0] end_a;
   logic [VidWidth-1:0] end_b;
   logic                last_edge;
   modport source (output valid, end_a, end_b, last_edge, input ready);
   modport sink (input valid, end_a, end_b, last_edge, output ready);
endinterface

interface apf_rsp_if import apf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VidWidth-1:0] vertex_id;
   logic                is_cut;
   logic                last_result;
   modport source (output valid, vertex_id, is_cut, last_result, input ready);
   modport sink (input valid, vertex_id, is_cut, last_result, output ready);
endinterface

@@ hw/rtl/articulation_point_finder_top.sv @@
// Top level of the articulation point finder: edge loading, depth-first search and result stream.
//
//   channel | direction | beat contents
//   req     | in        | end_a, end_b, last_edge (one undirected edge)
//   rsp     | out       | vertex_id, is_cut, last_result (one vertex)
//   csr     | in        | vertex_count, user must write it only while idle; not enforced
//
// An edge beat with both ends in range and distinct is written in steps: the accept cycle
// reads row a, the next writes row a and reads row b, and then row b is written. A self
// loop writes row a only, and an ignored edge writes nothing. After the beat marked last the
// search scans every column of each visited vertex's row and follows each set adjacency
// bit; the n results then stream out one a cycle while rsp.ready is high.
// Reset is synchronous and starts a clearing pass of the adjacency memory, one row a cycle
// over min(MAX_VERTICES, 64) rows, that also follows every graph; edges wait for it.
// A stalled response holds its beat in the output register and blocks the next graph.
module articulation_point_finder_top
   import apf_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDefault
) (
   input  logic             clock,
   input  logic             reset,
   apf_req_if.sink          req,
   apf_rsp_if.source        rsp,
   input  logic             csr_we,
   input  logic [CountWidth-1:0] csr_wdata
);
   // Rows and columns exist only below 64, the range of the 6-bit vertex fields.
   localparam int Depth = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

   // Storage: adjacency rows, per-vertex discovery time and low value, the stack.
   logic [Depth-1:0]     adj_mem   [Depth];
   logic [TimeWidth-1:0] disc_mem  [Depth];
   logic [TimeWidth-1:0] low_mem   [Depth];
   logic [AW-1:0]        stk_v_mem [Depth];
   logic [CountWidth-1:0] stk_p_mem [Depth];
   logic [Depth-1:0]     visited_ff, visited_in;
   logic [Depth-1:0]     cut_ff, cut_in;

   apf_state_type state_ff, state_in;
   logic [CountWidth-1:0] vcount_ff, vcount_in;
   logic [CountWidth-1:0] n_ff, n_in;
   logic [CountWidth-1:0] root_ff, root_in;      // root sweep / emit / clear index
   logic [CountWidth-1:0] depth_ff, depth_in;    // stack depth
   logic [TimeWidth-1:0]  time_ff, time_in;
   logic [1:0]            rchild_ff, rchild_in;  // saturating root child count
   logic [AW-1:0]         u_ff, u_in;            // vertex on top of stack
   logic [CountWidth-1:0] pos_ff, pos_in;        // scan column
   logic [AW-1:0]         par_ff, par_in;        // parent of u (valid if depth>1)
   logic [TimeWidth-1:0]  ulow_ff, ulow_in;      // low of u
   logic [Depth-1:0]      row_ff;                // registered adjacency read

   // Load pipeline: row writes of an edge, the first and then the mirrored one.
   logic          pend_ff, pend_in;
   logic          pend_first_ff, pend_first_in;
   logic          pend_last_ff, pend_last_in;
   logic [AW-1:0] pend_row_ff, pend_row_in, pend_col_ff, pend_col_in;
   logic          pend_more;

   // Memory port controls.
   logic          adj_we;
   logic [AW-1:0] adj_wa, adj_ra;
   logic [Depth-1:0] adj_wd;
   logic [AW-1:0] v_ra;                          // disc/low read address
   logic [TimeWidth-1:0] disc_rd, low_rd;
   logic          dl_we;
   logic [AW-1:0] dl_wa;
   logic [TimeWidth-1:0] disc_wd, low_wd;
   logic          low_only_we;
   logic [AW-1:0] low_only_wa;
   logic [TimeWidth-1:0] low_only_wd;
   logic          stk_we;
   logic [AW-1:0] stk_wa, stk_ra;
   logic [AW-1:0] stk_v_wd, stk_v_rd;
   logic [CountWidth-1:0] stk_p_wd, stk_p_rd;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VidWidth-1:0] rsp_id_ff, rsp_id_in;
   logic          rsp_cut_ff, rsp_cut_in, rsp_last_ff, rsp_last_in;

   logic [CountWidth-1:0] eff_n;
   logic                  req_fire, edge_ok;
   logic [CountWidth-1:0] col_next;
   logic                  col_hit;

   always_comb begin
      eff_n = (vcount_ff > CountWidth'(Depth)) ? CountWidth'(Depth) : vcount_ff;
   end

   assign req.ready = (state_ff == ST_LOAD) && !pend_ff;
   assign req_fire  = req.valid && req.ready;
   assign edge_ok   = ({1'b0, req.end_a} < eff_n) && ({1'b0, req.end_b} < eff_n);
   // A second row write follows only after the first write of a non-loop edge.
   assign pend_more = pend_first_ff && (pend_row_ff != pend_col_ff);

   // Memories, written and read in clocked blocks.
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= adj_wd;
      end
      row_ff <= adj_mem[adj_ra];
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         disc_mem[dl_wa] <= disc_wd;
      end
      if (dl_we) begin
         low_mem[dl_wa] <= low_wd;
      end else if (low_only_we) begin
         low_mem[low_only_wa] <= low_only_wd;
      end
      disc_rd <= disc_mem[v_ra];
      low_rd  <= low_mem[v_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_v_mem[stk_wa] <= stk_v_wd;
         stk_p_mem[stk_wa] <= stk_p_wd;
      end
      stk_v_rd <= stk_v_mem[stk_ra];
      stk_p_rd <= stk_p_mem[stk_ra];
   end

   // Scan helper: the current column of the registered row.
   always_comb begin
      col_hit  = (pos_ff < n_ff) && row_ff[pos_ff[AW-1:0]];
      col_next = pos_ff + CountWidth'(1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req.last_edge && !edge_ok) begin
               state_in = ST_ROOT;
            end else if (pend_ff && pend_last_ff && !pend_more) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_ff >= n_ff) begin
               state_in = (n_ff == '0) ? ST_CLEAR : ST_EMIT;
            end else if (!visited_ff[root_ff[AW-1:0]]) begin
               state_in = ST_TOP_RD;
            end
         end
         ST_TOP_RD: state_in = ST_SCAN;
         ST_SCAN: begin
            if (pos_ff >= n_ff) begin
               state_in = ST_POP;
            end else if (col_hit) begin
               state_in = ST_VISIT_RD;
            end
         end
         ST_VISIT_RD: state_in = ST_DESCEND;
         ST_DESCEND: state_in = ST_TOP_RD;
         ST_POP: state_in = (depth_ff > CountWidth'(1)) ? ST_BACK_RD : ST_ROOT;
         ST_BACK_RD: state_in = ST_POP_WR;
         ST_POP_WR: state_in = ST_TOP_RD;
         ST_EMIT: begin
            if (rsp_valid_ff && rsp.ready && rsp_last_ff) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (root_ff + CountWidth'(1) >= CountWidth'(Depth)) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      vcount_in   = csr_we ? csr_wdata : vcount_ff;
      n_in        = n_ff;
      root_in     = root_ff;
      depth_in    = depth_ff;
      time_in     = time_ff;
      rchild_in   = rchild_ff;
      u_in        = u_ff;
      pos_in      = pos_ff;
      par_in      = par_ff;
      ulow_in     = ulow_ff;
      visited_in  = visited_ff;
      cut_in      = cut_ff;
      pend_in     = 1'b0;
      pend_first_in = pend_first_ff;
      pend_last_in  = pend_last_ff;
      pend_row_in = pend_row_ff;
      pend_col_in = pend_col_ff;
      adj_we      = 1'b0;
      adj_wa      = '0;
      adj_wd      = '0;
      adj_ra      = u_ff;
      v_ra        = u_ff;
      dl_we       = 1'b0;
      dl_wa       = '0;
      disc_wd     = '0;
      low_wd      = '0;
      low_only_we = 1'b0;
      low_only_wa = '0;
      low_only_wd = '0;
      stk_we      = 1'b0;
      stk_wa      = '0;
      stk_v_wd    = '0;
      stk_p_wd    = '0;
      stk_ra      = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_cut_in   = rsp_cut_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            // The accept cycle reads row a; the first pending write writes row a and reads
            // row b; the mirrored pending write then writes row b.
            if (pend_ff) begin
               adj_we = 1'b1;
               adj_wa = pend_row_ff;
               adj_wd = row_ff | (Depth'(1) << pend_col_ff);
               if (pend_more) begin
                  pend_in       = 1'b1;
                  pend_first_in = 1'b0;
                  pend_row_in   = pend_col_ff;
                  pend_col_in   = pend_row_ff;
                  adj_ra        = pend_col_ff;
               end
            end else if (req_fire) begin
               adj_ra       = AW'(req.end_a);
               pend_last_in = req.last_edge;
               if (edge_ok) begin
                  pend_in       = 1'b1;
                  pend_first_in = 1'b1;
                  pend_row_in   = AW'(req.end_a);
                  pend_col_in   = AW'(req.end_b);
               end
               if (req.last_edge) begin
                  n_in       = eff_n;
                  root_in    = '0;
                  time_in    = '0;
                  depth_in   = '0;
                  visited_in = '0;
                  cut_in     = '0;
               end
            end
         end
         ST_ROOT: begin
            if (root_ff < n_ff && !visited_ff[root_ff[AW-1:0]]) begin
               // Visit the root.
               visited_in = visited_ff | (Depth'(1) << root_ff[AW-1:0]);
               time_in    = time_ff + TimeWidth'(1);
               dl_we      = 1'b1;
               dl_wa      = root_ff[AW-1:0];
               disc_wd    = time_ff + TimeWidth'(1);
               low_wd     = time_ff + TimeWidth'(1);
               ulow_in    = time_ff + TimeWidth'(1);
               stk_we     = 1'b1;
               stk_wa     = '0;
               stk_v_wd   = root_ff[AW-1:0];
               depth_in   = CountWidth'(1);
               rchild_in  = '0;
               u_in       = root_ff[AW-1:0];
               pos_in     = '0;
            end else if (root_ff < n_ff) begin
               root_in = root_ff + CountWidth'(1);
            end else begin
               root_in = '0;
            end
         end
         ST_TOP_RD: begin
            adj_ra = u_ff;
         end
         ST_SCAN: begin
            v_ra = pos_ff[AW-1:0];
            if (pos_ff < n_ff) begin
               pos_in = col_next;
            end
         end
         ST_VISIT_RD: begin
            // pos_ff is one past the neighbour w; disc_rd holds disc[w] and is
            // read again so that it stays there for the next cycle.
            v_ra     = AW'(pos_ff - CountWidth'(1));
            stk_we   = 1'b1;
            stk_wa   = AW'(depth_ff - CountWidth'(1));
            stk_v_wd = u_ff;
            stk_p_wd = pos_ff;
         end
         ST_DESCEND: begin
            if (!visited_ff[AW'(pos_ff - CountWidth'(1))]) begin
               if (depth_ff == CountWidth'(1) && rchild_ff != 2'd2) begin
                  rchild_in = rchild_ff + 2'd1;
               end
               visited_in = visited_ff | (Depth'(1) << AW'(pos_ff - CountWidth'(1)));
               time_in    = time_ff + TimeWidth'(1);
               dl_we      = 1'b1;
               dl_wa      = AW'(pos_ff - CountWidth'(1));
               disc_wd    = time_ff + TimeWidth'(1);
               low_wd     = time_ff + TimeWidth'(1);
               stk_we     = 1'b1;
               stk_wa     = AW'(depth_ff);
               stk_v_wd   = AW'(pos_ff - CountWidth'(1));
               stk_p_wd   = '0;
               depth_in   = depth_ff + CountWidth'(1);
               par_in     = u_ff;
               u_in       = AW'(pos_ff - CountWidth'(1));
               ulow_in    = time_ff + TimeWidth'(1);
               pos_in     = '0;
            end else begin
               if ((depth_ff == CountWidth'(1) || AW'(pos_ff - CountWidth'(1)) != par_ff)
                   && disc_rd < ulow_ff) begin
                  ulow_in     = disc_rd;
                  low_only_we = 1'b1;
                  low_only_wa = u_ff;
                  low_only_wd = disc_rd;
               end
            end
         end
         ST_POP: begin
            depth_in = depth_ff - CountWidth'(1);
            if (depth_ff > CountWidth'(1)) begin
               stk_ra = AW'(depth_ff - CountWidth'(2));
               v_ra   = par_ff;
            end else begin
               if (rchild_ff == 2'd2) begin
                  cut_in = cut_ff | (Depth'(1) << root_ff[AW-1:0]);
               end
               root_in = root_ff + CountWidth'(1);
            end
         end
         ST_BACK_RD: begin
            // Parent p = par_ff; low/disc of p are in low_rd/disc_rd.
            // Grandparent for the next level is read here from the stack.
            stk_ra  = (depth_ff > CountWidth'(1)) ? AW'(depth_ff - CountWidth'(2)) : '0;
            u_in    = par_ff;
            ulow_in = (ulow_ff < low_rd) ? ulow_ff : low_rd;
            if (ulow_ff < low_rd) begin
               low_only_we = 1'b1;
               low_only_wa = par_ff;
               low_only_wd = ulow_ff;
            end
            if (depth_ff > CountWidth'(1) && ulow_ff >= disc_rd) begin
               cut_in = cut_ff | (Depth'(1) << par_ff);
            end
            pos_in = stk_p_rd;
         end
         ST_POP_WR: begin
            par_in = stk_v_rd;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               if (!(rsp_valid_ff && rsp_last_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = VidWidth'(root_ff);
                  rsp_cut_in   = cut_ff[root_ff[AW-1:0]];
                  rsp_last_in  = (root_ff + CountWidth'(1) == n_ff);
                  root_in      = root_ff + CountWidth'(1);
               end else begin
                  root_in = '0;
               end
            end
         end
         ST_CLEAR: begin
            adj_we  = 1'b1;
            adj_wa  = root_ff[AW-1:0];
            adj_wd  = '0;
            root_in = root_ff + CountWidth'(1);
            if (root_ff + CountWidth'(1) >= CountWidth'(Depth)) begin
               root_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         vcount_ff    <= CountWidth'(VertexCountReset);
         root_ff      <= '0;
         depth_ff     <= '0;
         time_ff      <= '0;
         rchild_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         visited_ff   <= '0;
         cut_ff       <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         root_ff      <= root_in;
         depth_ff     <= depth_in;
         time_ff      <= time_in;
         rchild_ff    <= rchild_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         visited_ff   <= visited_in;
         cut_ff       <= cut_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff          <= u_in;
      pos_ff        <= pos_in;
      par_ff        <= par_in;
      ulow_ff       <= ulow_in;
      pend_first_ff <= pend_first_in;
      pend_last_ff  <= pend_last_in;
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cut_ff    <= rsp_cut_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.vertex_id   = rsp_id_ff;
   assign rsp.is_cut      = rsp_cut_ff;
   assign rsp.last_result = rsp_last_ff;
endmodule

@@ hw/rtl/apf_checker.sv @@
// Port-level checker for the articulation point finder, bound to the top level.
`include "articulation_point_finder_top_defines.svh"
module apf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_edge,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_result,
   input logic [5:0] rsp_vertex_id
);
   `APF_ASSERT_NEXT(a_no_req_after_last, clock, reset, req_valid && req_ready && req_last_edge, !req_ready, "request accepted right after the last edge")
   `APF_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "edges accepted while results stream")
   `APF_ASSERT_NEXT(a_ids_rise, clock, reset, rsp_valid && rsp_ready && !rsp_last_result, rsp_vertex_id == $past(rsp_vertex_id) + 6'd1 || !rsp_valid, "vertex numbers out of order")
   `APF_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vertex_id), "stalled result changed")
endmodule

bind articulation_point_finder_top apf_checker u_apf_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_last_edge(req.last_edge),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last_result(rsp.last_result),
   .rsp_vertex_id(rsp.vertex_id)
);
